@@ sv/assert_macros.svh @@
// Assertion macros shared by the angular motion profile RTL.
// Needs clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while reset is high
`define AMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also evaluated during reset
`define AMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/amp_pkg.sv @@
// Types, constants and helpers of the angular motion profile unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package amp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HEAD_W    = 19;
  localparam int RATE_W    = 24;
  localparam int TIME_W    = 24;
  localparam int FRACT_W   = 17;
  localparam int MAG_W     = 20;
  localparam int HW_W      = 22;   // heading arithmetic width
  localparam int TT_W      = 48;   // T squared
  localparam int EPS_W     = 36;   // |d| * 40000
  localparam int MD_Y_W    = 38;   // multiplier operand of the muldiv unit
  localparam int MD_CNT_W  = 6;

  localparam logic signed [HW_W-1:0] PI_FIX     = 22'sd205887;
  localparam logic signed [HW_W-1:0] TWO_PI_FIX = 22'sd411775;
  localparam logic [15:0]            EPS_INV    = 16'd40000;
  localparam logic [FRACT_W-1:0]     FRACT_ONE  = 17'd65536;
  localparam logic [RATE_W-2:0]      RATE_MAX   = '1;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic                      first;
    logic signed [HEAD_W-1:0]  begin_rot;
    logic signed [HEAD_W-1:0]  end_rot;
    logic [MAG_W-1:0]          delta_mag;
    logic                      delta_neg;
    logic [TIME_W-1:0]         dur;
    logic [FRACT_W-1:0]        frac;
    logic [TIME_W-1:0]         now;
  } cmd_t;

  // Request to the iterative floor(x*y/d) unit
  typedef struct packed {
    logic              start;
    logic [TT_W-1:0]   x;
    logic [MD_Y_W-1:0] y;
    logic [TT_W-1:0]   d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [MD_Y_W-1:0] q;
  } md_rsp_t;

  // One wrap step into [-pi, pi]
  function automatic logic signed [HW_W-1:0] wrap_step(input logic signed [HW_W-1:0] h);
    if (h > PI_FIX) begin
      return h - TWO_PI_FIX;
    end else if (h < -PI_FIX) begin
      return h + TWO_PI_FIX;
    end
    return h;
  endfunction

endpackage

@@ sv/amp_front.sv @@
// Front of the profile unit: accepts path points, wraps the heading change,
// clamps the fraction and registers one classified item. Uses amp_pkg.
`timescale 1ns / 1ps

module amp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  first_of_segment,
  input  logic [18:0]           begin_head,
  input  logic [18:0]           end_head,
  input  logic [23:0]           segment_duration,
  input  logic [16:0]           rotation_fraction,
  input  logic [23:0]           point_time,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output amp_pkg::cmd_t         cmd
);
  import amp_pkg::*;

  logic                   ent_valid;
  cmd_t                   ent_next;
  logic signed [HW_W-1:0] d_raw;
  logic signed [HW_W-1:0] d_wrap;
  logic signed [HW_W-1:0] d_abs;

  // Heading change, wrapped once
  always_comb begin
    d_raw  = HW_W'($signed(end_head)) - HW_W'($signed(begin_head));
    d_wrap = wrap_step(d_raw);
    d_abs  = d_wrap[HW_W-1] ? -d_wrap : d_wrap;
    ent_next.first     = first_of_segment;
    ent_next.begin_rot = $signed(begin_head);
    ent_next.end_rot   = $signed(end_head);
    ent_next.delta_mag = d_abs[MAG_W-1:0];
    ent_next.delta_neg = d_wrap[HW_W-1];
    ent_next.dur       = segment_duration;
    ent_next.frac      = (rotation_fraction > FRACT_ONE) ? FRACT_ONE : rotation_fraction;
    ent_next.now       = point_time;
  end

  assign in_ready  = !ent_valid || cmd_ready;
  assign cmd_valid = ent_valid;

  // Item register
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (in_ready) begin
      ent_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd <= ent_next;
    end
  end

endmodule

@@ sv/amp_queue.sv @@
// Short queue of classified items between the front and the back.
// Uses amp_pkg for the item type.
`timescale 1ns / 1ps

module amp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          can_push,
  input  amp_pkg::cmd_t push_data,
  output logic          has_data,
  input  logic          pop,
  output amp_pkg::cmd_t pop_data
);
  import amp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign can_push = (count != CNT_W'(DEPTH));
  assign has_data = (count != '0);
  assign do_push  = push && can_push;
  assign do_pop   = pop && has_data;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/amp_muldiv.sv @@
// Iterative floor(x*y/d) unit, one bit of y per cycle, for x < d.
// Uses amp_pkg for the request and response structs.
`timescale 1ns / 1ps

module amp_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  amp_pkg::md_req_t req,
  output amp_pkg::md_rsp_t rsp
);
  import amp_pkg::*;

  logic                busy;
  logic [MD_CNT_W-1:0] cnt;
  logic [TT_W-1:0]     r;
  logic [MD_Y_W-1:0]   q;
  logic [TT_W-1:0]     x;
  logic [MD_Y_W-1:0]   y;
  logic [TT_W-1:0]     d;
  logic                done;

  logic [TT_W:0]       dbl;
  logic                b1;
  logic [TT_W:0]       r1;
  logic [TT_W:0]       sum;
  logic                b2;
  logic [TT_W-1:0]     r_next;
  logic [MD_Y_W-1:0]   q_next;

  // One step: double the remainder mod d, then add x mod d if the bit is set
  always_comb begin
    dbl    = {r, 1'b0};
    b1     = dbl >= {1'b0, d};
    r1     = b1 ? dbl - {1'b0, d} : dbl;
    sum    = {1'b0, r1[TT_W-1:0]} + {1'b0, x};
    b2     = y[MD_Y_W-1] && (sum >= {1'b0, d});
    r_next = y[MD_Y_W-1] ? (b2 ? sum[TT_W-1:0] - d : sum[TT_W-1:0]) : r1[TT_W-1:0];
    q_next = {q[MD_Y_W-2:0], 1'b0} + MD_Y_W'(b1) + MD_Y_W'(b2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= MD_CNT_W'(MD_Y_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      x <= req.x;
      y <= req.y;
      d <= req.d;
      r <= '0;
      q <= '0;
    end else if (busy) begin
      r <= r_next;
      q <= q_next;
      y <= {y[MD_Y_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.q    = q;

endmodule

@@ sv/amp_back.sv @@
// Back of the profile unit: segment state, profile sequencer and result
// register. Uses amp_pkg, amp_muldiv and assert_macros.svh.
`timescale 1ns / 1ps

module amp_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_pop,
  input  amp_pkg::cmd_t           cmd,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [18:0]             heading,
  output logic [23:0]             angular_rate,
  output logic                    rotation_finished,
  output logic                    zero_time_error
);
  import amp_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_SEG_T     = 13'b0000000000010,
    S_SEG_TT    = 13'b0000000000100,
    S_SEG_BASE  = 13'b0000000001000,
    S_PT_T      = 13'b0000000010000,
    S_PT_SEL    = 13'b0000000100000,
    S_SQ        = 13'b0000001000000,
    S_OFF_GO    = 13'b0000010000000,
    S_OFF_WAIT  = 13'b0000100000000,
    S_RATE_GO   = 13'b0001000000000,
    S_RATE_WAIT = 13'b0010000000000,
    S_FINISH    = 13'b0100000000000,
    S_SPARE     = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  cmd_t                     cur;
  logic [TIME_W-1:0]        seg_start;
  logic signed [HEAD_W-1:0] start_hd;
  logic signed [HEAD_W-1:0] target_hd;
  logic [MAG_W-1:0]         mag;
  logic                     neg;
  logic [TIME_W-1:0]        rot_t;
  logic [TT_W-1:0]          tt;
  logic [EPS_W-1:0]         eps;
  logic [MAG_W-1:0]         decel_base;
  logic                     done_marked;
  logic                     zero_seen;
  logic [TIME_W-1:0]        t;
  logic                     accel_phase;
  logic [TIME_W-1:0]        span;
  logic [TT_W-1:0]          sq;
  logic [MAG_W-1:0]         off;
  logic [RATE_W-2:0]        rate_mag;
  logic signed [HW_W-1:0]   hd_pre;
  logic                     fin;
  logic                     err;
  logic                     load;
  logic [40:0]              dur_prod;
  logic signed [HW_W-1:0]   hd_wrapped;
  logic signed [RATE_W-1:0] rate_signed;
  logic                     md_waiting;
  logic                     err_res;
  logic                     res_moving;

  md_req_t md_req;
  md_rsp_t md_rsp;

  amp_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign dur_prod    = cur.dur * cur.frac;
  assign load        = (state == S_FINISH) && (!res_valid || res_ready);
  assign cmd_pop     = (state == S_IDLE) && cmd_valid;
  assign hd_wrapped  = wrap_step(wrap_step(hd_pre));
  assign rate_signed = neg ? -$signed({1'b0, rate_mag}) : $signed({1'b0, rate_mag});

  // Muldiv requests
  always_comb begin
    md_req.start = (state == S_OFF_GO) || (state == S_RATE_GO);
    md_req.d     = tt;
    if (state == S_RATE_GO) begin
      md_req.x = TT_W'(span);
      md_req.y = {mag, 18'b0};
    end else begin
      md_req.x = sq;
      md_req.y = MD_Y_W'({mag, 1'b0});
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (cmd_valid) state_next = cmd.first ? S_SEG_T : S_PT_T;
      S_SEG_T:     state_next = S_SEG_TT;
      S_SEG_TT:    state_next = S_SEG_BASE;
      S_SEG_BASE:  state_next = S_PT_T;
      S_PT_T:      state_next = S_PT_SEL;
      S_PT_SEL: begin
        if (rot_t == '0 || t > rot_t) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SQ;
        end
      end
      S_SQ:        state_next = S_OFF_GO;
      S_OFF_GO:    state_next = S_OFF_WAIT;
      S_OFF_WAIT:  if (md_rsp.done) state_next = S_RATE_GO;
      S_RATE_GO:   state_next = S_RATE_WAIT;
      S_RATE_WAIT: if (md_rsp.done) state_next = S_FINISH;
      S_FINISH:    if (load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      seg_start   <= '0;
      start_hd    <= '0;
      target_hd   <= '0;
      mag         <= '0;
      neg         <= 1'b0;
      rot_t       <= '0;
      tt          <= '0;
      decel_base  <= '0;
      done_marked <= 1'b0;
      zero_seen   <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      // Segment latch and profile constants
      if (state == S_SEG_T) begin
        rot_t       <= dur_prod[39:16];
        seg_start   <= cur.now;
        start_hd    <= cur.begin_rot;
        target_hd   <= cur.end_rot;
        mag         <= cur.delta_mag;
        neg         <= cur.delta_neg;
        done_marked <= 1'b0;
      end
      if (state == S_SEG_TT) begin
        tt        <= rot_t * rot_t;
        zero_seen <= (rot_t == '0);
      end
      if (state == S_SEG_BASE) begin
        decel_base <= ({4'b0, tt} < {eps, 16'b0}) ? mag : (mag >> 1);
      end
      if (state == S_PT_SEL && rot_t != '0 && t > rot_t) begin
        done_marked <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state == S_SEG_TT) begin
      eps <= mag * EPS_INV;
    end
    if (state == S_PT_T) begin
      t <= (cur.now >= seg_start) ? cur.now - seg_start : '0;
    end
    // Phase selection
    if (state == S_PT_SEL) begin
      fin      <= 1'b0;
      err      <= 1'b0;
      rate_mag <= '0;
      hd_pre   <= HW_W'(target_hd);
      if (rot_t == '0) begin
        err <= zero_seen;
      end else if (t > rot_t) begin
        fin <= !done_marked;
      end else begin
        accel_phase <= {t, 1'b0} < {1'b0, rot_t};
        span        <= ({t, 1'b0} < {1'b0, rot_t}) ? t : rot_t - t;
      end
    end
    if (state == S_SQ) begin
      sq <= span * span;
    end
    if (state == S_OFF_WAIT && md_rsp.done) begin
      off <= accel_phase ? md_rsp.q[MAG_W-1:0] : decel_base - md_rsp.q[MAG_W-1:0];
    end
    if (state == S_RATE_WAIT && md_rsp.done) begin
      rate_mag <= (md_rsp.q > MD_Y_W'(RATE_MAX)) ? RATE_MAX : md_rsp.q[RATE_W-2:0];
      hd_pre   <= neg ? HW_W'(start_hd) - HW_W'(off) : HW_W'(start_hd) + HW_W'(off);
    end
    // Result register
    if (load) begin
      heading           <= hd_wrapped[HEAD_W-1:0];
      angular_rate      <= rate_signed;
      rotation_finished <= fin;
      zero_time_error   <= err;
    end
  end

  // Terms for the checks below
  assign md_waiting = (state == S_OFF_WAIT) || (state == S_RATE_WAIT);
  assign err_res    = res_valid && zero_time_error;
  assign res_moving = (angular_rate != '0) || rotation_finished;

  `AMP_ASSERT(a_err_no_motion, err_res |-> !res_moving, "zero time result carries motion")
  `AMP_ASSERT(a_md_done_waited, md_rsp.done |-> md_waiting, "muldiv finished with no waiter")
  `AMP_ASSERT_ALWAYS(a_rst_empty, rst |=> !res_valid, "result valid after reset")

endmodule

@@ sv/angular_motion_profile_unit.sv @@
// Angular motion profile unit: per path point, a triangular-rate heading
// profile over the current segment. Needs amp_pkg, amp_front, amp_queue, amp_back.
`timescale 1ns / 1ps

// One result per input point, in order. An item reaches the back part through
// the front's item register and then the queue. In the back a point outside the
// rotation window (zero rotation time, or past its end) skips the multiply-divide
// unit; a point inside it makes two passes (38 steps and a done strobe each)
// through the shared bit-serial multiply-divide unit (heading offset, then
// rate). A point that opens a segment first passes the segment-constant states
// S_SEG_T, S_SEG_TT and S_SEG_BASE. A result that waits on the output holds
// the back in S_FINISH. Input points are buffered in a register plus a
// QUEUE_DEPTH-entry queue, so the input keeps accepting while a result waits
// on the output, until both are full. No clearing pass after reset.
module angular_motion_profile_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // begin_head[18:0], end_head[37:19], segment_duration[61:38],
  // rotation_fraction[78:62], point_time[102:79], zero pad [103]
  input  logic [103:0] s_tdata,
  // first_of_segment[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // heading[18:0], angular_rate[42:19], zero pad [47:43]
  output logic [47:0]  m_tdata,
  // rotation_finished[0], zero_time_error[1]
  output logic [1:0]   m_tuser
);
  import amp_pkg::*;

  logic        fr_valid;
  logic        q_can_push;
  cmd_t        fr_cmd;
  logic        q_has_data;
  logic        q_pop;
  cmd_t        q_cmd;
  logic [18:0] heading;
  logic [23:0] angular_rate;
  logic        rotation_finished;
  logic        zero_time_error;

  amp_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .first_of_segment  (s_tuser),
    .begin_head        (s_tdata[18:0]),
    .end_head          (s_tdata[37:19]),
    .segment_duration  (s_tdata[61:38]),
    .rotation_fraction (s_tdata[78:62]),
    .point_time        (s_tdata[102:79]),
    .cmd_valid         (fr_valid),
    .cmd_ready         (q_can_push),
    .cmd               (fr_cmd)
  );

  amp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fr_valid),
    .can_push  (q_can_push),
    .push_data (fr_cmd),
    .has_data  (q_has_data),
    .pop       (q_pop),
    .pop_data  (q_cmd)
  );

  amp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (q_has_data),
    .cmd_pop           (q_pop),
    .cmd               (q_cmd),
    .res_valid         (m_tvalid),
    .res_ready         (m_tready),
    .heading           (heading),
    .angular_rate      (angular_rate),
    .rotation_finished (rotation_finished),
    .zero_time_error   (zero_time_error)
  );

  assign m_tdata = {5'b0, angular_rate, heading};
  assign m_tuser = {zero_time_error, rotation_finished};

endmodule
